[design/wnms_pkg.sv]
package wnms_pkg;

  // Table geometry and value format
  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int INDEX_W     = 10;
  localparam int OUT_W       = 11;

  // Weighting arithmetic
  localparam int FRAC_W    = 16;
  localparam int SCALE_W   = FRAC_W + 1;
  localparam int MAG_W     = VALUE_WIDTH + 1;
  localparam int PROD_W    = MAG_W + SCALE_W;
  localparam int COST_W    = VALUE_WIDTH + 3;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << FRAC_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCALE_W;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = CFG_IDX_W'(1);
  localparam logic [CNT_W-1:0]     COUNT_RESET     = CNT_W'(1024);

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

[design/weighted_nearest_match_search.sv]
// Weighted nearest-match search. A load beat (operation 0) writes one candidate
// entry, position and offset, into table slot entry_index. A query beat
// (operation 1) scans entries 0 to entry_count-1 and returns the one-based index
// of the entry with the lowest cost ((|query - position| * scale) >> 16) +
// offset, the earliest entry on a tie. A query holds off new beats until its
// result is in the output register: the single read port of the candidate table
// delivers one entry per cycle into a distance, weighting and compare pipeline.
// A finished result waits in the output register while the next beat is taken.
// Scale saturates at 1.0, entry_count is capped at the table depth, and the
// table has no reset: a query must only reach entries loaded before it.
module weighted_nearest_match_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic [wnms_pkg::INDEX_W-1:0]         entry_index_i,
  input  logic signed [wnms_pkg::VALUE_WIDTH-1:0] entry_position_i,
  input  logic signed [wnms_pkg::VALUE_WIDTH-1:0] entry_offset_i,
  input  logic signed [wnms_pkg::VALUE_WIDTH-1:0] query_position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [wnms_pkg::OUT_W-1:0]           best_index_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wnms_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wnms_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int W = wnms_pkg::VALUE_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [wnms_pkg::SCALE_W-1:0] scale_q;
  logic [wnms_pkg::CNT_W-1:0]   entry_count_q;

  // Query context
  logic [W-1:0]                 query_q;
  logic [wnms_pkg::CNT_W-1:0]   scan_len_q;
  logic [wnms_pkg::CNT_W-1:0]   issue_cnt_q;
  logic [wnms_pkg::CNT_W-1:0]   cmp_cnt_q;

  // Pipeline stages
  logic                         rd_valid_q;
  logic [2*W-1:0]               rd_data_q;
  logic                         mag_valid_q;
  logic [wnms_pkg::MAG_W-1:0]   mag_q;
  logic [W-1:0]                 mag_off_q;
  logic                         wt_valid_q;
  logic [wnms_pkg::MAG_W-1:0]   wt_q;
  logic [W-1:0]                 wt_off_q;

  // Running minimum
  logic [wnms_pkg::COST_W-1:0]  best_cost_q;
  logic [wnms_pkg::ADDR_W-1:0]  best_idx_q;

  logic                         out_valid_q;
  logic [wnms_pkg::OUT_W-1:0]   best_index_q;

  // Candidate table: position in the upper half, offset in the lower half
  logic [2*W-1:0] table_q [wnms_pkg::MAX_ENTRIES];

  logic                         in_fire;
  logic                         cfg_fire;
  logic                         wr_en;
  logic                         rd_en;
  logic [wnms_pkg::ADDR_W-1:0]  wr_addr;
  logic [wnms_pkg::CNT_W-1:0]   scan_len_d;
  logic [wnms_pkg::SCALE_W-1:0] scale_eff;
  logic [W-1:0]                 rd_pos;
  logic [W-1:0]                 rd_off;
  logic [wnms_pkg::MAG_W-1:0]   diff;
  logic [wnms_pkg::MAG_W-1:0]   mag_d;
  logic [wnms_pkg::PROD_W-1:0]  prod;
  logic [wnms_pkg::COST_W-1:0]  cost;
  logic                         take_new;
  logic                         last_cmp;
  logic                         out_free;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign best_index_o = best_index_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Decode load write and scan read
  assign wr_addr = wnms_pkg::ADDR_W'(entry_index_i);
  assign wr_en   = in_fire && (operation_i == wnms_pkg::OP_LOAD) &&
                   (32'(entry_index_i) < 32'(wnms_pkg::MAX_ENTRIES));
  assign rd_en   = (state_q == ST_SCAN) && (issue_cnt_q < scan_len_q);

  // Cap the scan length at the table depth
  assign scan_len_d = (entry_count_q > wnms_pkg::CNT_W'(wnms_pkg::MAX_ENTRIES)) ?
                      wnms_pkg::CNT_W'(wnms_pkg::MAX_ENTRIES) : entry_count_q;

  // Saturate the weight at 1.0
  assign scale_eff = (scale_q > wnms_pkg::SCALE_ONE) ? wnms_pkg::SCALE_ONE : scale_q;

  // Stage 1: absolute distance
  assign rd_pos = rd_data_q[2*W-1:W];
  assign rd_off = rd_data_q[W-1:0];
  assign diff   = {query_q[W-1], query_q} - {rd_pos[W-1], rd_pos};
  assign mag_d  = diff[wnms_pkg::MAG_W-1] ? (wnms_pkg::MAG_W'(0) - diff) : diff;

  // Stage 2: weight and drop the fraction
  assign prod = wnms_pkg::PROD_W'(mag_q) * wnms_pkg::PROD_W'(scale_eff);

  // Stage 3: add offset and compare
  assign cost     = {2'b00, wt_q} + {{2{wt_off_q[W-1]}}, wt_off_q[W-1], wt_off_q};
  assign take_new = (cmp_cnt_q == '0) || ($signed(cost) < $signed(best_cost_q));
  assign last_cmp = wt_valid_q && ((cmp_cnt_q + wnms_pkg::CNT_W'(1)) == scan_len_q);

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= {entry_position_i, entry_offset_i};
    end
    if (rd_en) begin
      rd_data_q <= table_q[issue_cnt_q[wnms_pkg::ADDR_W-1:0]];
    end
  end

  // Control, pipeline and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scale_q       <= wnms_pkg::SCALE_ONE;
      entry_count_q <= wnms_pkg::COUNT_RESET;
      query_q       <= '0;
      scan_len_q    <= '0;
      issue_cnt_q   <= '0;
      cmp_cnt_q     <= '0;
      rd_valid_q    <= 1'b0;
      mag_valid_q   <= 1'b0;
      mag_q         <= '0;
      mag_off_q     <= '0;
      wt_valid_q    <= 1'b0;
      wt_q          <= '0;
      wt_off_q      <= '0;
      best_cost_q   <= '0;
      best_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      best_index_q  <= '0;
    end else begin
      // Take configuration writes; ignore unknown indexes
      if (cfg_fire) begin
        case (cfg_index_i)
          wnms_pkg::REG_SCALE:       scale_q <= cfg_data_i;
          wnms_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data_i[wnms_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      // Publish a finished result; drop it once taken
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Advance the pipeline
      rd_valid_q  <= rd_en;
      mag_valid_q <= rd_valid_q;
      mag_q       <= mag_d;
      mag_off_q   <= rd_off;
      wt_valid_q  <= mag_valid_q;
      wt_q        <= prod[wnms_pkg::FRAC_W +: wnms_pkg::MAG_W];
      wt_off_q    <= mag_off_q;

      if (rd_en) begin
        issue_cnt_q <= issue_cnt_q + wnms_pkg::CNT_W'(1);
      end

      // Track the running minimum
      if (wt_valid_q) begin
        cmp_cnt_q <= cmp_cnt_q + wnms_pkg::CNT_W'(1);
        if (take_new) begin
          best_cost_q <= cost;
          best_idx_q  <= cmp_cnt_q[wnms_pkg::ADDR_W-1:0];
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire && (operation_i == wnms_pkg::OP_QUERY)) begin
            query_q     <= query_position_i;
            scan_len_q  <= scan_len_d;
            issue_cnt_q <= '0;
            cmp_cnt_q   <= '0;
            best_idx_q  <= '0;
            state_q     <= (scan_len_d == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_cmp) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            best_index_q <= wnms_pkg::OUT_W'(best_idx_q) + wnms_pkg::OUT_W'(1);
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Never issue more reads than the scan length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (issue_cnt_q <= scan_len_q))
    else $error("scan read issued past scan length");

  // Pipeline beats only exist during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q || mag_valid_q || wt_valid_q) |-> (state_q == ST_SCAN))
    else $error("pipeline beat outside a scan");

  // Winner lies inside the scanned range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && scan_len_q != '0) |->
      (wnms_pkg::CNT_W'(best_idx_q) < scan_len_q))
    else $error("best index outside scanned range");

  // A finished query publishes its result when the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished query did not publish");

  // Loads never collide with a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !rd_en)
    else $error("table write during scan read");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef logic signed [wnms_pkg::VALUE_WIDTH-1:0] value_t;
  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_e;

  // Register indexes past the two real ones; writes there must be dropped
  localparam logic [wnms_pkg::CFG_IDX_W-1:0] REG_SPARE_A = wnms_pkg::CFG_IDX_W'(2);
  localparam logic [wnms_pkg::CFG_IDX_W-1:0] REG_SPARE_B = wnms_pkg::CFG_IDX_W'(3);
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    row_kind_e                             kind;
    logic [wnms_pkg::INDEX_W-1:0]          slot;
    value_t                                pos;
    value_t                                off;
    value_t                                qpos;
    logic [wnms_pkg::CFG_IDX_W-1:0]        reg_idx;
    logic [wnms_pkg::CFG_DATA_W-1:0]       reg_data;
    bit                                    typed;
    logic [wnms_pkg::OUT_W-1:0]            best;
  } stim_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic                              operation_i;
  logic [wnms_pkg::INDEX_W-1:0]      entry_index_i;
  value_t                            entry_position_i;
  value_t                            entry_offset_i;
  value_t                            query_position_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [wnms_pkg::OUT_W-1:0]        best_index_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [wnms_pkg::CFG_IDX_W-1:0]    cfg_index_i;
  logic [wnms_pkg::CFG_DATA_W-1:0]   cfg_data_i;

  // Shadow copy of the candidate table and registers
  value_t                            pos_tab [wnms_pkg::MAX_ENTRIES];
  value_t                            off_tab [wnms_pkg::MAX_ENTRIES];
  bit                                loaded [wnms_pkg::MAX_ENTRIES];
  int                                loaded_prefix = 0;
  logic [wnms_pkg::SCALE_W-1:0]      scale_reg = wnms_pkg::SCALE_ONE;
  logic [wnms_pkg::OUT_W-1:0]        count_reg = wnms_pkg::OUT_W'(wnms_pkg::COUNT_RESET);

  logic [wnms_pkg::OUT_W-1:0]        best_due [$];
  logic [wnms_pkg::OUT_W-1:0]        best_want;
  stim_row_t                         directed_rows [$];
  int                                fail_count = 0;
  int                                burst_left = 0;
  bit                                hold_off_req = 1'b0;

  weighted_nearest_match_search DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .entry_index_i    (entry_index_i),
    .entry_position_i (entry_position_i),
    .entry_offset_i   (entry_offset_i),
    .query_position_i (query_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .best_index_o     (best_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Scan the shadow table and return the one-based index of the cheapest entry
  function automatic logic [wnms_pkg::OUT_W-1:0] predict_best_index(value_t q);
    longint          delta;
    longint          cost;
    longint          best_cost;
    longint unsigned mag;
    longint unsigned weight;
    longint unsigned s;
    int              n;
    int              best;
    s = (scale_reg > wnms_pkg::SCALE_ONE) ? longint'(wnms_pkg::SCALE_ONE) :
        longint'(scale_reg);
    n = (int'(count_reg) > wnms_pkg::MAX_ENTRIES) ? wnms_pkg::MAX_ENTRIES : int'(count_reg);
    best = 0;
    best_cost = 0;
    for (int j = 0; j < n; j++) begin
      delta = longint'(q) - longint'(pos_tab[j]);
      mag = (delta < 0) ? longint'(-delta) : longint'(delta);
      weight = (mag * s) >> wnms_pkg::FRAC_W;
      cost = longint'(weight) + longint'(off_tab[j]);
      if (j == 0 || cost < best_cost) begin
        best_cost = cost;
        best = j;
      end
    end
    return wnms_pkg::OUT_W'(best + 1);
  endfunction

  // Pick a value: full range, narrow around zero, extremes, or near a loaded entry
  function automatic value_t rand_value();
    value_t v;
    case ($urandom_range(0, 6))
      0, 1:    v = value_t'($urandom);
      2:       v = value_t'(int'($urandom_range(0, 2097152)) - 1048576);
      3:       v = {1'b1, {(wnms_pkg::VALUE_WIDTH-1){1'b0}}};
      4:       v = {1'b0, {(wnms_pkg::VALUE_WIDTH-1){1'b1}}};
      default: begin
        if (loaded_prefix > 0)
          v = pos_tab[$urandom_range(0, loaded_prefix - 1)]
              + value_t'(int'($urandom_range(0, 512)) - 256);
        else
          v = value_t'($urandom);
      end
    endcase
    return v;
  endfunction

  function automatic void add_load(logic [wnms_pkg::INDEX_W-1:0] slot, value_t pos,
                                   value_t off);
    stim_row_t r;
    r = '0;
    r.kind = ROW_LOAD;
    r.slot = slot;
    r.pos = pos;
    r.off = off;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_query(value_t q, bit typed, logic [wnms_pkg::OUT_W-1:0] best);
    stim_row_t r;
    r = '0;
    r.kind = ROW_QUERY;
    r.qpos = q;
    r.typed = typed;
    r.best = best;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [wnms_pkg::CFG_IDX_W-1:0] idx,
                                  logic [wnms_pkg::CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_data = data;
    directed_rows.push_back(r);
  endfunction

  // Offer one beat in bursts with random gaps; log it once accepted
  task automatic send_beat(logic op, logic [wnms_pkg::INDEX_W-1:0] slot, value_t pos,
                           value_t off, value_t q, bit typed,
                           logic [wnms_pkg::OUT_W-1:0] typed_best);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    entry_index_i    <= slot;
    entry_position_i <= pos;
    entry_offset_i   <= off;
    query_position_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == wnms_pkg::OP_LOAD) begin
      pos_tab[slot] = pos;
      off_tab[slot] = off;
      loaded[slot] = 1'b1;
      while (loaded_prefix < wnms_pkg::MAX_ENTRIES && loaded[loaded_prefix]) loaded_prefix++;
    end else begin
      best_due.push_back(typed ? typed_best : predict_best_index(q));
    end
  endtask

  task automatic send_query(value_t q);
    send_beat(wnms_pkg::OP_QUERY, wnms_pkg::INDEX_W'($urandom), value_t'($urandom),
              value_t'($urandom), q, 1'b0, '0);
  endtask

  task automatic send_load(logic [wnms_pkg::INDEX_W-1:0] slot, value_t pos, value_t off);
    send_beat(wnms_pkg::OP_LOAD, slot, pos, off, value_t'($urandom), 1'b0, '0);
  endtask

  // Drop valid, wait for every result, then let any trailing load retire
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (best_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [wnms_pkg::CFG_IDX_W-1:0] idx,
                           logic [wnms_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == wnms_pkg::REG_SCALE)
      scale_reg = data;
    else if (idx == wnms_pkg::REG_ENTRY_COUNT)
      count_reg = data[wnms_pkg::OUT_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One phase: new settings, fill the scanned slots, then mostly queries
  task automatic run_random_phase(int beats, bit press);
    int                              n;
    int                              roll;
    logic [wnms_pkg::OUT_W-1:0]      cnt;
    logic [wnms_pkg::SCALE_W-1:0]    sc;
    logic [wnms_pkg::INDEX_W-1:0]    slot;
    value_t                          p;
    value_t                          o;
    value_t                          q;
    settle();
    case ($urandom_range(0, 5))
      0:       sc = '0;
      1:       sc = wnms_pkg::SCALE_W'(1);
      2:       sc = wnms_pkg::SCALE_ONE;
      3:       sc = wnms_pkg::SCALE_W'($urandom_range(65537, 131071));
      default: sc = wnms_pkg::SCALE_W'($urandom_range(0, 65536));
    endcase
    roll = $urandom_range(0, 9);
    if (roll == 0)
      cnt = '0;
    else if (roll < 8)
      cnt = wnms_pkg::OUT_W'($urandom_range(1, 16));
    else
      cnt = wnms_pkg::OUT_W'($urandom_range(17, 64));
    write_reg(wnms_pkg::REG_SCALE, sc);
    write_reg(wnms_pkg::REG_ENTRY_COUNT, {6'($urandom_range(0, 63)), cnt});
    n = int'(cnt);
    if (press) hold_off_req = 1'b1;
    repeat (beats) begin
      p = rand_value();
      o = rand_value();
      q = rand_value();
      roll = $urandom_range(0, 9);
      if (loaded_prefix < n) begin
        send_load(wnms_pkg::INDEX_W'(loaded_prefix), p, o);
      end else if (roll < 6) begin
        if (n > 0 && $urandom_range(0, 2) == 0)
          q = pos_tab[$urandom_range(0, n - 1)] + value_t'(int'($urandom_range(0, 64)) - 32);
        send_query(q);
      end else begin
        if (roll < 9 && n > 0)
          slot = wnms_pkg::INDEX_W'($urandom_range(0, n - 1));
        else
          slot = wnms_pkg::INDEX_W'($urandom_range(0, wnms_pkg::MAX_ENTRIES - 1));
        // copy entry zero to force a tie that the earliest entry must win
        if (roll == 8 && loaded_prefix > 0) begin
          p = pos_tab[0];
          o = off_tab[0];
        end
        send_load(slot, p, o);
      end
    end
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (best_due.size() == 0) begin
        $display("%0t: unexpected result, best_index expected none actual %0d",
                 $time, best_index_o);
        fail_count++;
      end else begin
        best_want = best_due.pop_front();
        if (best_index_o !== best_want) begin
          $display("%0t: best_index mismatch, expected %0d actual %0d",
                   $time, best_want, best_index_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver: stall on its own pattern, with one long hold-off on request
  initial begin : receiver
    int run_len;
    int mode;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      run_len = $urandom_range(4, 40);
      mode = $urandom_range(0, 3);
      repeat (run_len) begin
        @(negedge clk_i);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    value_t vmin;
    value_t vmax;
    vmin = {1'b1, {(wnms_pkg::VALUE_WIDTH-1){1'b0}}};
    vmax = {1'b0, {(wnms_pkg::VALUE_WIDTH-1){1'b1}}};
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    operation_i      = wnms_pkg::OP_LOAD;
    entry_index_i    = '0;
    entry_position_i = '0;
    entry_offset_i   = '0;
    query_position_i = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = wnms_pkg::REG_SCALE;
    cfg_data_i       = '0;
    foreach (loaded[i]) loaded[i] = 1'b0;

    // Directed rows: empty scan, extremes, ties, scale limits, dead registers
    add_cfg(wnms_pkg::REG_ENTRY_COUNT, '0);
    add_query('0, 1'b1, wnms_pkg::OUT_W'(1));
    add_query(vmin, 1'b1, wnms_pkg::OUT_W'(1));
    add_load(wnms_pkg::INDEX_W'(0), vmax, vmin);
    add_load(wnms_pkg::INDEX_W'(1), vmin, vmax);
    add_cfg(wnms_pkg::REG_ENTRY_COUNT, wnms_pkg::CFG_DATA_W'(1));
    add_query(vmin, 1'b1, wnms_pkg::OUT_W'(1));
    add_cfg(wnms_pkg::REG_ENTRY_COUNT, wnms_pkg::CFG_DATA_W'(2));
    add_query(vmax, 1'b0, '0);
    add_query(vmin, 1'b0, '0);
    add_load({wnms_pkg::INDEX_W{1'b1}}, value_t'(5), '0);
    add_cfg(wnms_pkg::REG_SCALE, '0);
    add_query(value_t'(32'h1234_5678), 1'b1, wnms_pkg::OUT_W'(1));
    add_cfg(wnms_pkg::REG_SCALE, {wnms_pkg::CFG_DATA_W{1'b1}});
    add_query(vmax, 1'b0, '0);
    add_cfg(REG_SPARE_A, wnms_pkg::CFG_DATA_W'(5));
    add_cfg(REG_SPARE_B, '0);
    add_load(wnms_pkg::INDEX_W'(2), '0, '0);
    add_load(wnms_pkg::INDEX_W'(3), '0, '0);
    add_cfg(wnms_pkg::REG_ENTRY_COUNT, wnms_pkg::CFG_DATA_W'(4));
    add_cfg(wnms_pkg::REG_SCALE, wnms_pkg::CFG_DATA_W'(32768));
    add_query('0, 1'b0, '0);
    add_query(value_t'(32'h0001_0000), 1'b0, '0);
    add_cfg(wnms_pkg::REG_SCALE, wnms_pkg::CFG_DATA_W'(1));
    add_query(value_t'(-1), 1'b0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed rows
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        end
        ROW_LOAD: send_load(directed_rows[i].slot, directed_rows[i].pos, directed_rows[i].off);
        default: send_beat(wnms_pkg::OP_QUERY, '0, '0, '0, directed_rows[i].qpos,
                           directed_rows[i].typed, directed_rows[i].best);
      endcase
    end

    // Random phases; one of them holds the receiver off for a long stretch
    for (int ph = 0; ph < 14; ph++) run_random_phase(40, ph == 3);

    // Drain and report
    settle();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
